// File: design/ccs_pkg.sv
// Shared types and constants for the calendar clock with stopwatch.
// No dependencies; imported by ccs_core and calendar_clock_with_stopwatch.
`default_nettype none

package ccs_pkg;

    // Input commands
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_START = 3'd1,
        MODE_PAUSE = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_SET   = 3'd4
    } mode_t;

    // Kinds of result record
    typedef enum logic [1:0] {
        KIND_CLOCK   = 2'd0,
        KIND_ELAPSED = 2'd1,
        KIND_START   = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    localparam int RESULT_DEPTH = 4;

    localparam logic [5:0]  MIN_MINUTES_RESET = 6'd1;
    localparam logic [6:0]  SECS_PER_MIN      = 7'd60;
    localparam logic [6:0]  MINS_PER_HOUR     = 7'd60;
    localparam logic [5:0]  HOURS_PER_DAY     = 6'd24;
    localparam logic [3:0]  MONTHS_LIMIT      = 4'd13;
    localparam logic [13:0] YEAR_MAX          = 14'd9999;
    localparam logic [11:0] DAYS_MAX          = 12'd4095;
    localparam logic [4:0]  LONG_MONTH        = 5'd31;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // One input item
    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } item_t;

    // One result record
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [13:0] year;
        logic [3:0]  month;
        logic [11:0] day;
        logic        kept;
        logic        tracking;
        logic        paused;
        logic        last;
    } rec_t;

endpackage

`default_nettype wire

// File: design/ccs_core.sv
// Clock, calendar and stopwatch state with the per-item update and result build.
// Depends on ccs_pkg.
`default_nettype none

module ccs_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  ccs_pkg::item_t   item,
    input  logic             cfg_we,
    input  logic [5:0]       cfg_data,
    output ccs_pkg::rec_t    rec_first,
    output ccs_pkg::rec_t    rec_second,
    output logic             two_results
);
    import ccs_pkg::*;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } stamp_t;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [11:0] days;
    } elapsed_t;

    localparam stamp_t CLOCK_RESET = '{
        hours: 5'd10, minutes: 6'd43, seconds: 6'd34,
        year: 14'd2023, month: 4'd11, day: 5'd17
    };

    stamp_t   clock_reg,   clock_next;
    stamp_t   start_reg,   start_next;
    elapsed_t elapsed_reg, elapsed_next;
    logic     running_reg, running_next;
    logic     paused_reg,  paused_next;
    logic [5:0] min_minutes_reg;

    function automatic logic [4:0] month_len(logic [3:0] mo);
        logic [4:0] len;
        len = LONG_MONTH;
        if (mo inside {[4'd1:4'd12]})
            len = MONTH_DAYS[mo - 4'd1];
        return len;
    endfunction

    // Advance the wall clock by one second, carrying through the calendar
    function automatic stamp_t clock_advance(stamp_t t);
        stamp_t     n;
        logic [6:0] s;
        logic [6:0] m;
        logic [5:0] h;
        logic [5:0] d;
        logic [3:0] mo;
        n  = t;
        s  = {1'b0, t.seconds} + 7'd1;
        m  = {1'b0, t.minutes} + 7'd1;
        h  = {1'b0, t.hours} + 6'd1;
        d  = {1'b0, t.day} + 6'd1;
        mo = t.month + 4'd1;
        if (s >= SECS_PER_MIN) begin
            n.seconds = '0;
            if (m >= MINS_PER_HOUR) begin
                n.minutes = '0;
                if (h >= HOURS_PER_DAY) begin
                    n.hours = '0;
                    if (d > {1'b0, month_len(t.month)}) begin
                        n.day = 5'd1;
                        if (mo == 4'd0 || mo >= MONTHS_LIMIT) begin
                            n.month = 4'd1;
                            if (t.year < YEAR_MAX)
                                n.year = t.year + 14'd1;
                        end
                        else begin
                            n.month = mo;
                        end
                    end
                    else begin
                        n.day = d[4:0];
                    end
                end
                else begin
                    n.hours = h[4:0];
                end
            end
            else begin
                n.minutes = m[5:0];
            end
        end
        else begin
            n.seconds = s[5:0];
        end
        return n;
    endfunction

    // Advance the session timer by one second; days saturate
    function automatic elapsed_t elapsed_advance(elapsed_t t);
        elapsed_t   n;
        logic [6:0] s;
        logic [6:0] m;
        logic [5:0] h;
        n = t;
        s = {1'b0, t.seconds} + 7'd1;
        m = {1'b0, t.minutes} + 7'd1;
        h = {1'b0, t.hours} + 6'd1;
        if (s >= SECS_PER_MIN) begin
            n.seconds = '0;
            if (m >= MINS_PER_HOUR) begin
                n.minutes = '0;
                if (h >= HOURS_PER_DAY) begin
                    n.hours = '0;
                    if (t.days < DAYS_MAX)
                        n.days = t.days + 12'd1;
                end
                else begin
                    n.hours = h[4:0];
                end
            end
            else begin
                n.minutes = m[5:0];
            end
        end
        else begin
            n.seconds = s[5:0];
        end
        return n;
    endfunction

    function automatic rec_t stamp_rec(kind_t kind, stamp_t t, logic kept, logic last,
                                       logic tracking, logic paused);
        rec_t r;
        r.kind     = kind;
        r.hours    = t.hours;
        r.minutes  = t.minutes;
        r.seconds  = t.seconds;
        r.year     = t.year;
        r.month    = t.month;
        r.day      = {7'd0, t.day};
        r.kept     = kept;
        r.tracking = tracking;
        r.paused   = paused;
        r.last     = last;
        return r;
    endfunction

    function automatic rec_t elapsed_rec(elapsed_t t, logic last, logic tracking,
                                         logic paused);
        rec_t r;
        r.kind     = KIND_ELAPSED;
        r.hours    = t.hours;
        r.minutes  = t.minutes;
        r.seconds  = t.seconds;
        r.year     = '0;
        r.month    = '0;
        r.day      = t.days;
        r.kept     = 1'b0;
        r.tracking = tracking;
        r.paused   = paused;
        r.last     = last;
        return r;
    endfunction

    stamp_t item_stamp;
    logic   kept;
    stamp_t end_stamp;

    assign item_stamp = '{
        hours: item.hours, minutes: item.minutes, seconds: item.seconds,
        year: item.year, month: item.month, day: item.day
    };
    assign kept      = elapsed_reg.minutes >= min_minutes_reg;
    assign end_stamp = kept ? clock_reg : '0;

    always_comb
    begin
        clock_next   = clock_reg;
        start_next   = start_reg;
        elapsed_next = elapsed_reg;
        running_next = running_reg;
        paused_next  = paused_reg;
        case (item.mode)
            MODE_TICK:
            begin
                clock_next = clock_advance(clock_reg);
                if (running_reg && !paused_reg)
                    elapsed_next = elapsed_advance(elapsed_reg);
            end
            MODE_START:
            begin
                if (!running_reg) begin
                    elapsed_next = '0;
                    start_next   = clock_reg;
                end
                running_next = 1'b1;
            end
            MODE_PAUSE:
            begin
                if (running_reg)
                    paused_next = !paused_reg;
            end
            MODE_STOP:
            begin
                if (!kept)
                    start_next = '0;
                running_next = 1'b0;
            end
            MODE_SET:
            begin
                clock_next = item_stamp;
            end
            default:
            begin
                clock_next = clock_reg;
            end
        endcase
    end

    // Build the records from the updated state
    always_comb
    begin
        two_results = 1'b0;
        rec_first   = stamp_rec(KIND_CLOCK, clock_next, 1'b0, 1'b0, running_next, paused_next);
        rec_second  = elapsed_rec(elapsed_next, 1'b1, running_next, paused_next);
        case (item.mode)
            MODE_TICK:
            begin
                two_results = 1'b1;
            end
            MODE_START:
            begin
                rec_first = stamp_rec(KIND_START, start_next, 1'b0, 1'b0,
                                      running_next, paused_next);
            end
            MODE_PAUSE:
            begin
                rec_first = elapsed_rec(elapsed_next, 1'b0, running_next, paused_next);
            end
            MODE_STOP:
            begin
                two_results = 1'b1;
                rec_first   = stamp_rec(KIND_START, start_next, kept, 1'b0,
                                        running_next, paused_next);
                rec_second  = stamp_rec(KIND_END, end_stamp, kept, 1'b1,
                                        running_next, paused_next);
            end
            default:
            begin
                two_results = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clock_reg   <= CLOCK_RESET;
            start_reg   <= '0;
            elapsed_reg <= '0;
            running_reg <= 1'b0;
            paused_reg  <= 1'b0;
        end
        else if (take) begin
            clock_reg   <= clock_next;
            start_reg   <= start_next;
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
            paused_reg  <= paused_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_minutes_reg <= MIN_MINUTES_RESET;
        else if (cfg_we)
            min_minutes_reg <= cfg_data;
    end

endmodule

`default_nettype wire

// File: design/calendar_clock_with_stopwatch.sv
// Calendar clock with session stopwatch: top level with the result queue.
// Depends on ccs_pkg and ccs_core.
// Records: both records of an item are written into the result queue when the item is
// taken, and they leave the queue in order through the single-record result port.
// Throughput: one item per cycle while item_stall is low; tick and stop make two records,
// so a stream of them is limited by the single-record result port.
// Reset: clock 2023-11-17 10:43:34, session idle, threshold 1 minute, queue empty.
`default_nettype none

module calendar_clock_with_stopwatch #(
    // Result queue entries; a power of two, at least 2
    parameter int QDEPTH = ccs_pkg::RESULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  mode,
    input  logic [4:0]  set_hours,
    input  logic [5:0]  set_minutes,
    input  logic [5:0]  set_seconds,
    input  logic [13:0] set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,

    // Result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  record_kind,
    output logic [4:0]  out_hours,
    output logic [5:0]  out_minutes,
    output logic [5:0]  out_seconds,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [11:0] out_day,
    output logic        session_kept,
    output logic        tracking_on,
    output logic        paused_on,
    output logic        last,

    // Threshold register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
    import ccs_pkg::*;

    localparam int IW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    item_t item;
    rec_t  rec_first;
    rec_t  rec_second;
    logic  two_results;
    logic  take;
    logic  pop;
    rec_t  head;

    // Result queue: each item pushes one or two records
    rec_t           queue [QDEPTH];
    logic [IW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic [1:0]     push_n;

    assign item = '{
        mode: mode, hours: set_hours, minutes: set_minutes, seconds: set_seconds,
        year: set_year, month: set_month, day: set_day
    };

    // Hold off new items unless room for two records remains
    assign item_stall   = count_reg > CW'(QDEPTH - 2);
    assign take         = item_valid && !item_stall;
    assign result_valid = count_reg != '0;
    assign pop          = result_valid && !result_stall;

    // User must keep the block idle whenever the register is written; it is not enforced
    assign cfg_ready = 1'b1;

    ccs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (item),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .rec_first   (rec_first),
        .rec_second  (rec_second),
        .two_results (two_results)
    );

    always_comb
    begin
        push_n = 2'd0;
        if (take)
            push_n = two_results ? 2'd2 : 2'd1;
        wr_ptr_next = wr_ptr_reg + IW'(push_n);
        rd_ptr_next = rd_ptr_reg + IW'(pop);
        count_next  = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take) begin
            queue[wr_ptr_reg] <= rec_first;
            if (two_results)
                queue[wr_ptr_reg + IW'(1)] <= rec_second;
        end
    end

    // Drive the result port from the queue head; it holds while stalled
    assign head         = queue[rd_ptr_reg];
    assign record_kind  = head.kind;
    assign out_hours    = head.hours;
    assign out_minutes  = head.minutes;
    assign out_seconds  = head.seconds;
    assign out_year     = head.year;
    assign out_month    = head.month;
    assign out_day      = head.day;
    assign session_kept = head.kept;
    assign tracking_on  = head.tracking;
    assign paused_on    = head.paused;
    assign last         = head.last;

endmodule

`default_nettype wire
